/* hw/rtl/x86alu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86alu_pkg
// Shared types and command codes for the 16-bit ALU with flags.
// ----------------------------------------------------------------------------
package x86alu_pkg;

  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_CMP = 4'd2;
  localparam logic [3:0] CMD_AND = 4'd3;
  localparam logic [3:0] CMD_OR  = 4'd4;
  localparam logic [3:0] CMD_XOR = 4'd5;
  localparam logic [3:0] CMD_INC = 4'd6;
  localparam logic [3:0] CMD_DEC = 4'd7;
  localparam logic [3:0] CMD_NEG = 4'd8;
  localparam logic [3:0] CMD_DIV = 4'd9;

  localparam int DIV_STEPS = 16;   // one quotient bit per stage
  localparam int DIV_DEPTH = DIV_STEPS + 1;

  typedef struct packed {
    logic        valid;
    logic [15:0] result;
    logic        write_back;
    logic [4:0]  flags;
    logic        is_div;
  } alu_res_t;

  // Divider state carried down the stages.
  typedef struct packed {
    logic        valid;
    logic        wide;
    logic        is_div;
    logic        err;
    logic [16:0] rem;     // partial remainder
    logic [31:0] num;     // dividend bits still to shift in (msb first)
    logic [15:0] quo;
    logic [15:0] dvs;
  } div_stage_t;

endpackage

/* hw/rtl/x86alu_arith.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86alu_arith
// Non-divide operations and flag update, one registered stage.
// ----------------------------------------------------------------------------
module x86alu_arith import x86alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [3:0]  cmd,
  input  logic        word_size,
  input  logic [15:0] dest_value,
  input  logic [15:0] src_value,
  input  logic [4:0]  flags_in,
  output alu_res_t    res_r
);

  alu_res_t    res_nxt;
  logic [15:0] d, s, r, msk, sgn;
  logic [16:0] sum, dif;
  logic        c_add, c_sub;

  always_comb begin
    msk = word_size ? 16'hFFFF : 16'h00FF;
    sgn = word_size ? 16'h8000 : 16'h0080;
    d = dest_value & msk;
    s = src_value & msk;
    sum = {1'b0, d} + {1'b0, s};
    dif = {1'b0, d} - {1'b0, s};
    c_add = word_size ? sum[16] : sum[8];
    c_sub = d < s;
    r = 16'd0;
    res_nxt.flags = flags_in;
    res_nxt.write_back = 1'b1;
    res_nxt.valid = in_valid;
    res_nxt.is_div = (cmd == CMD_DIV);
    case (cmd)
      CMD_ADD: begin
        r = sum[15:0] & msk;
        res_nxt.flags = {|((d ^ r) & (s ^ r) & sgn), 2'b00,
                         ((d ^ s ^ r) & 16'h0010) != 16'd0, c_add};
      end
      CMD_SUB, CMD_CMP: begin
        r = dif[15:0] & msk;
        res_nxt.flags = {|((d ^ s) & (d ^ r) & sgn), 2'b00,
                         ((d ^ s ^ r) & 16'h0010) != 16'd0, c_sub};
        res_nxt.write_back = (cmd == CMD_SUB);
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        r = (cmd == CMD_AND) ? (d & s) : (cmd == CMD_OR) ? (d | s) : (d ^ s);
        res_nxt.flags[4] = 1'b0;
        res_nxt.flags[0] = 1'b0;
      end
      CMD_INC: begin
        r = (d + 16'd1) & msk;
        res_nxt.flags[4] = (d == sgn - 16'd1);
      end
      CMD_DEC: begin
        r = (d - 16'd1) & msk;
        res_nxt.flags[4] = (d == sgn);
      end
      CMD_NEG: begin
        r = (16'd0 - d) & msk;
        res_nxt.flags[0] = (d != 16'd0);
      end
      default: res_nxt.write_back = 1'b0;
    endcase
    if (cmd <= CMD_NEG) begin
      res_nxt.flags[2] = (r == 16'd0);
      res_nxt.flags[3] = |(r & sgn);
    end
    res_nxt.result = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* hw/rtl/x86alu_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86alu_div_stage
// One restoring-division step: one quotient bit, registered.
// ----------------------------------------------------------------------------
module x86alu_div_stage import x86alu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  div_stage_t d_in,
  output div_stage_t d_r
);

  div_stage_t  d_nxt;
  logic [17:0] trial;
  logic [17:0] shifted;

  always_comb begin
    d_nxt = d_in;
    shifted = {d_in.rem, d_in.num[31]};
    trial = shifted - {2'b00, d_in.dvs};
    d_nxt.num = {d_in.num[30:0], 1'b0};
    if (!trial[17]) begin
      d_nxt.rem = trial[16:0];
      d_nxt.quo = {d_in.quo[14:0], 1'b1};
    end else begin
      d_nxt.rem = shifted[16:0];
      d_nxt.quo = {d_in.quo[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

/* hw/rtl/x86_16bit_alu_with_flags.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_16bit_alu_with_flags
// 8086-style byte/word ALU with flags and pipelined unsigned divide.
// ----------------------------------------------------------------------------
// Usage: present an operation on the in_ channel (valid/ready); one result
// transaction per input leaves on the out_ channel in the same order.
// Every operation, divide included, flows through a fixed pipeline of
// 18 register stages: an entry stage that pre-checks the divisor, sixteen
// restoring-division stages (one quotient bit each, the sixteen quotient
// bits set the depth) and the output register. Non-divide
// results are computed in the first stage and ride alongside.
// Throughput is one transaction per cycle while the receiver does not stall.
// Reset clears all valid bits; the pipeline is empty afterward.
// When the receiver stalls the whole pipeline holds, except that bubbles
// are squeezed out, so in_ready stays high until every stage is full.
// ----------------------------------------------------------------------------
module x86_16bit_alu_with_flags import x86alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_cmd,
  input  logic        in_word_size,
  input  logic [15:0] in_dest_value,
  input  logic [15:0] in_src_value,
  input  logic [15:0] in_div_high,
  input  logic [4:0]  in_flags_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result,
  output logic [15:0] out_remainder,
  output logic        out_write_back,
  output logic [4:0]  out_flags_out,
  output logic        out_divide_error
);

  // Stage 0 holds the ALU result plus divider setup.
  alu_res_t   alu_r [DIV_DEPTH+1];
  div_stage_t dv    [DIV_STEPS+1];
  logic       en    [DIV_DEPTH+1];
  alu_res_t   alu_nxt0;
  div_stage_t dv_nxt0;
  logic [15:0] s8;
  logic [31:0] num;
  logic        ovf;

  // Stage k may load when it is empty or its content moves on.
  assign en[DIV_DEPTH] = out_ready || !alu_r[DIV_DEPTH].valid;
  genvar k;
  generate
    for (k = 0; k < DIV_DEPTH; k++) begin : g_en
      assign en[k] = en[k+1] || !alu_r[k].valid;
    end
  endgenerate
  assign in_ready = en[0];

  x86alu_arith u_arith (
    .clk(clk), .rst_n(rst_n), .en(en[0]), .in_valid(in_valid),
    .cmd(in_cmd), .word_size(in_word_size), .dest_value(in_dest_value),
    .src_value(in_src_value), .flags_in(in_flags_in), .res_r(alu_r[0])
  );

  // Quotient overflows width iff the high part of the dividend >= divisor.
  // The partial remainder starts from DX for a word divide (zero for a byte
  // divide), and the sixteen dividend bits of AX are shifted in msb first.
  always_comb begin
    s8 = in_word_size ? in_src_value : {8'd0, in_src_value[7:0]};
    num = {in_dest_value, 16'd0};
    ovf = in_word_size ? (in_div_high >= s8) : ({8'd0, in_dest_value[15:8]} >= s8);
    dv_nxt0.valid = in_valid;
    dv_nxt0.wide = in_word_size;
    dv_nxt0.is_div = (in_cmd == CMD_DIV);
    dv_nxt0.err = (s8 == 16'd0) || ovf;
    dv_nxt0.rem = in_word_size ? {1'b0, in_div_high} : 17'd0;
    dv_nxt0.num = num;
    dv_nxt0.quo = 16'd0;
    dv_nxt0.dvs = s8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv[0].valid <= 1'b0;
    end else if (en[0]) begin
      dv[0] <= dv_nxt0;
    end
  end

  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
      x86alu_div_stage u_stage (
        .clk(clk), .rst_n(rst_n), .en(en[k+1]), .d_in(dv[k]), .d_r(dv[k+1])
      );
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          alu_r[k+1].valid <= 1'b0;
        end else if (en[k+1]) begin
          alu_r[k+1] <= alu_r[k];
        end
      end
    end
  endgenerate

  // Final stage merges the divide outcome into the result register.
  alu_res_t    fin_nxt;
  logic [15:0] rem_nxt, rem_r;
  logic        derr_nxt, derr_r;
  div_stage_t  dl;

  always_comb begin
    dl = dv[DIV_STEPS];
    fin_nxt = alu_r[DIV_STEPS];
    rem_nxt = 16'd0;
    derr_nxt = 1'b0;
    if (fin_nxt.is_div) begin
      if (dl.err) begin
        derr_nxt = 1'b1;
        fin_nxt.result = 16'd0;
        fin_nxt.write_back = 1'b0;
      end else begin
        fin_nxt.result = dl.wide ? dl.quo : {8'd0, dl.quo[7:0]};
        rem_nxt = dl.rem[15:0];
        fin_nxt.write_back = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alu_r[DIV_DEPTH].valid <= 1'b0;
    end else if (en[DIV_DEPTH]) begin
      alu_r[DIV_DEPTH] <= fin_nxt;
      rem_r <= rem_nxt;
      derr_r <= derr_nxt;
    end
  end

  assign out_valid = alu_r[DIV_DEPTH].valid;
  assign out_result = alu_r[DIV_DEPTH].result;
  assign out_remainder = rem_r;
  assign out_write_back = alu_r[DIV_DEPTH].write_back;
  assign out_flags_out = alu_r[DIV_DEPTH].flags;
  assign out_divide_error = derr_r;

endmodule

/* tb/x86_16bit_alu_with_flags_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_16bit_alu_with_flags_test
// Self-checking bench for the byte/word ALU with flags and divide. Directed
// corner operations are followed by random traffic under several idle and
// stall phases; each result transaction is compared with a local prediction.
// ----------------------------------------------------------------------------
module x86_16bit_alu_with_flags_test;
  import x86alu_pkg::*;

  localparam logic [4:0] FLG_C = 5'h01;
  localparam logic [4:0] FLG_A = 5'h02;
  localparam logic [4:0] FLG_Z = 5'h04;
  localparam logic [4:0] FLG_S = 5'h08;
  localparam logic [4:0] FLG_O = 5'h10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [3:0]  cmd;
    logic        word_size;
    logic [15:0] dest_value;
    logic [15:0] src_value;
    logic [15:0] div_high;
    logic [4:0]  flags_in;
  } alu_op_t;

  typedef struct packed {
    logic [15:0] result;
    logic [15:0] remainder;
    logic        write_back;
    logic [4:0]  flags_out;
    logic        divide_error;
  } alu_out_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [3:0] in_cmd;
  logic in_word_size;
  logic [15:0] in_dest_value, in_src_value, in_div_high;
  logic [4:0] in_flags_in;
  logic out_valid, out_ready;
  logic [15:0] out_result, out_remainder;
  logic out_write_back, out_divide_error;
  logic [4:0] out_flags_out;

  x86_16bit_alu_with_flags dut (.*);

  alu_op_t  pending_ops[$];
  alu_out_t expected_results[$];
  int error_count = 0;
  int checked_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  bit stimulus_done = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] zs_flags(logic [4:0] fl, logic [15:0] r, logic wide);
    fl &= ~(FLG_Z | FLG_S);
    if (r == 0) fl |= FLG_Z;
    if (wide ? r[15] : r[7]) fl |= FLG_S;
    return fl;
  endfunction

  function automatic alu_out_t predict_alu(alu_op_t op);
    alu_out_t o;
    logic [16:0] mask, sign, d, s, full;
    logic [15:0] r;
    logic [31:0] dividend, quo;
    logic [4:0] fl;
    o = '0;
    mask = op.word_size ? 17'hFFFF : 17'hFF;
    sign = op.word_size ? 17'h8000 : 17'h80;
    d = {1'b0, op.dest_value} & mask;
    s = {1'b0, op.src_value} & mask;
    fl = op.flags_in;
    r = 0;
    case (op.cmd)
      CMD_ADD: begin
        full = d + s;
        r = full[15:0] & mask[15:0];
        fl = 0;
        if (full > mask) fl |= FLG_C;
        if ((d[15:0] ^ s[15:0] ^ r) & 16'h10) fl |= FLG_A;
        if (((d[15:0] ^ r) & (s[15:0] ^ r)) & sign[15:0]) fl |= FLG_O;
        fl = zs_flags(fl, r, op.word_size);
        o.write_back = 1;
      end
      CMD_SUB, CMD_CMP: begin
        r = (d[15:0] - s[15:0]) & mask[15:0];
        fl = 0;
        if (d < s) fl |= FLG_C;
        if ((d[15:0] ^ s[15:0] ^ r) & 16'h10) fl |= FLG_A;
        if (((d[15:0] ^ s[15:0]) & (d[15:0] ^ r)) & sign[15:0]) fl |= FLG_O;
        fl = zs_flags(fl, r, op.word_size);
        o.write_back = (op.cmd == CMD_SUB);
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        if (op.cmd == CMD_AND) r = d[15:0] & s[15:0];
        else if (op.cmd == CMD_OR) r = d[15:0] | s[15:0];
        else r = d[15:0] ^ s[15:0];
        fl &= ~(FLG_O | FLG_C);
        fl = zs_flags(fl, r, op.word_size);
        o.write_back = 1;
      end
      CMD_INC: begin
        r = (d[15:0] + 16'd1) & mask[15:0];
        fl &= ~FLG_O;
        if (d == sign - 1) fl |= FLG_O;
        fl = zs_flags(fl, r, op.word_size);
        o.write_back = 1;
      end
      CMD_DEC: begin
        r = (d[15:0] - 16'd1) & mask[15:0];
        fl &= ~FLG_O;
        if (d == sign) fl |= FLG_O;
        fl = zs_flags(fl, r, op.word_size);
        o.write_back = 1;
      end
      CMD_NEG: begin
        r = (16'd0 - d[15:0]) & mask[15:0];
        fl &= ~FLG_C;
        if (d != 0) fl |= FLG_C;
        fl = zs_flags(fl, r, op.word_size);
        o.write_back = 1;
      end
      CMD_DIV: begin
        dividend = op.word_size ? {op.div_high, op.dest_value} : {16'd0, op.dest_value};
        if (s == 0) o.divide_error = 1;
        else begin
          quo = dividend / {15'd0, s};
          if (quo > {15'd0, mask}) o.divide_error = 1;
          else begin
            r = quo[15:0];
            o.remainder = 16'(dividend % {15'd0, s});
            o.write_back = 1;
          end
        end
      end
      default: ;
    endcase
    o.result = r;
    o.flags_out = fl;
    return o;
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    int pick;
    op.cmd = (($urandom_range(0, 19)) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
    op.word_size = 1'($urandom_range(0, 1));
    op.flags_in = 5'($urandom);
    op.div_high = 16'($urandom);
    pick = $urandom_range(0, 9);
    op.dest_value = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 :
                    (pick == 2) ? (op.word_size ? 16'h7FFF : 16'h007F) :
                    (pick == 3) ? (op.word_size ? 16'h8000 : 16'h0080) : 16'($urandom);
    pick = $urandom_range(0, 9);
    op.src_value = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom);
    // Keep most divides in range so that quotients are actually exercised.
    if (op.cmd == CMD_DIV && $urandom_range(0, 3) != 0) begin
      if (op.word_size) begin
        if (op.src_value == 0) op.src_value = 1;
        op.div_high = 16'($urandom_range(0, op.src_value - 1));
      end else begin
        if (op.src_value[7:0] == 0) op.src_value[7:0] = 1;
        op.dest_value[15:8] = 8'($urandom_range(0, op.src_value[7:0] - 1));
      end
    end
    return op;
  endfunction

  task automatic add_op(logic [3:0] c, logic w, logic [15:0] d, logic [15:0] s,
                        logic [15:0] h, logic [4:0] f);
    pending_ops.push_back({c, w, d, s, h, f});
  endtask

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    error_count++;
    $display("MISMATCH %s at result %0d: got %h, expected %h", field, checked_count, got, want);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        alu_op_t op;
        op = pending_ops.pop_front();
        expected_results.push_back(predict_alu(op));
        in_valid <= 1;
        {in_cmd, in_word_size, in_dest_value, in_src_value, in_div_high, in_flags_in} <= op;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", out_result, 16'd0);
        end else begin
          alu_out_t e;
          e = expected_results.pop_front();
          if (out_result !== e.result) report_mismatch("result", out_result, e.result);
          if (out_remainder !== e.remainder)
            report_mismatch("remainder", out_remainder, e.remainder);
          if (out_write_back !== e.write_back)
            report_mismatch("write_back", {15'd0, out_write_back}, {15'd0, e.write_back});
          if (out_flags_out !== e.flags_out)
            report_mismatch("flags_out", {11'd0, out_flags_out}, {11'd0, e.flags_out});
          if (out_divide_error !== e.divide_error)
            report_mismatch("divide_error", {15'd0, out_divide_error},
                            {15'd0, e.divide_error});
        end
        checked_count++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) pending_ops.push_back(random_op());
    while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_cmd = 0; in_word_size = 0; in_dest_value = 0; in_src_value = 0;
    in_div_high = 0; in_flags_in = 0;
    out_ready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // Directed corners: carries, overflow, zero, sign, divide errors.
    add_op(CMD_ADD, 0, 16'h00FF, 16'h0001, 0, 5'h1F);
    add_op(CMD_ADD, 1, 16'h7FFF, 16'h0001, 0, 5'h00);
    add_op(CMD_ADD, 1, 16'hFFFF, 16'hFFFF, 0, 5'h00);
    add_op(CMD_SUB, 0, 16'h0080, 16'h0001, 0, 5'h00);
    add_op(CMD_SUB, 1, 16'h0000, 16'h0001, 0, 5'h1F);
    add_op(CMD_CMP, 1, 16'h1234, 16'h1234, 0, 5'h00);
    add_op(CMD_AND, 1, 16'hFFFF, 16'h8000, 0, 5'h1F);
    add_op(CMD_OR,  0, 16'hFF00, 16'h0000, 0, 5'h13);
    add_op(CMD_XOR, 1, 16'hAAAA, 16'hFFFF, 0, 5'h00);
    add_op(CMD_INC, 0, 16'h007F, 0, 0, 5'h03);
    add_op(CMD_INC, 1, 16'hFFFF, 0, 0, 5'h00);
    add_op(CMD_DEC, 1, 16'h8000, 0, 0, 5'h1F);
    add_op(CMD_DEC, 0, 16'h0000, 0, 0, 5'h00);
    add_op(CMD_NEG, 1, 16'h0000, 0, 0, 5'h1F);
    add_op(CMD_NEG, 1, 16'h8000, 0, 0, 5'h00);
    add_op(CMD_NEG, 0, 16'h0001, 0, 0, 5'h00);
    add_op(CMD_DIV, 0, 16'hFFFF, 16'h0000, 0, 5'h15);
    add_op(CMD_DIV, 0, 16'hFEFF, 16'h00FF, 0, 5'h0A);
    add_op(CMD_DIV, 0, 16'hFF00, 16'h00FF, 0, 5'h00);
    add_op(CMD_DIV, 1, 16'hFFFF, 16'hFFFF, 16'hFFFE, 5'h1F);
    add_op(CMD_DIV, 1, 16'h0000, 16'h0001, 16'h0001, 5'h00);
    add_op(CMD_DIV, 1, 16'h1234, 16'h0000, 16'h0000, 5'h00);
    add_op(4'd15, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'h1F);
    run_phase(0, 0, 0);
    run_phase(0, 0, 400);
    run_phase(46, 0, 400);
    run_phase(0, 46, 400);
    run_phase(29, 29, 500);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered all ten operations, unused codes and divide errors at both widths,");
    $display("%0d results checked across idle and stall phases.", checked_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
